[hdl/ptr_pkg.sv]
package ptr_pkg;

    localparam int unsigned PTR_CH_W     = 8;
    localparam int unsigned PTR_LANES    = 3;
    localparam int unsigned PTR_CELLS    = PTR_CH_W;
    localparam int unsigned PTR_NUM_W    = 2 * PTR_CH_W;
    localparam int unsigned PTR_ADDR_W   = 3;
    localparam int unsigned PTR_DATA_W   = 32;

    localparam logic [PTR_CH_W-1:0] PTR_MAX_CHANNEL = 8'd255;
    localparam logic [PTR_CH_W-1:0] PTR_UNIT_DIV    = 8'd1;

    // register index, taken from paddr[2]
    localparam logic PTR_REG_MODE = 1'b0;

    typedef enum logic [1:0] {
        MODE_GRAY     = 2'd0,
        MODE_RGB      = 2'd1,
        MODE_STRAIGHT = 2'd2,
        MODE_PREMUL   = 2'd3
    } ptr_mode_t;

    // partial remainder and the numerator bits still to come / quotient bits so far
    typedef struct packed {
        logic [PTR_CH_W-1:0] rem;
        logic [PTR_CH_W-1:0] low;
    } ptr_lane_t;

    typedef struct packed {
        ptr_lane_t [PTR_LANES-1:0] lane;
        logic [PTR_LANES-1:0]      sat;
        logic [PTR_CH_W-1:0]       divisor;
        logic [PTR_CH_W-1:0]       alpha;
        logic                      last;
    } ptr_item_t;

    typedef struct packed {
        logic [PTR_CH_W-1:0] alpha;
        logic [PTR_CH_W-1:0] blue;
        logic [PTR_CH_W-1:0] green;
        logic [PTR_CH_W-1:0] red;
        logic                last;
    } ptr_pix_t;

endpackage

[hdl/pixel_to_rgba8_unpremultiply.sv]
// channel   dir  handshake             payload
// s_        in   s_tvalid / s_tready   s_tdata: samples first..fourth, s_tlast: last_in
// m_        out  m_tvalid / m_tready   m_tdata: red, green, blue, alpha_out, m_tlast: last_out
// apb       in   psel/penable/pready   mode at address 0
//
// one item per cycle while s_tready is high; a taken item passes through
// eight divider cells, one quotient bit each, then the output register
// reset clears mode to gray and empties the cell row and the output buffer
// when the output stalls, the second output entry fills and s_tready drops
// until it drains; the whole cell row holds while s_tready is low
module pixel_to_rgba8_unpremultiply
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // first, second, third, fourth
    input  logic                               s_tlast,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,  // red, green, blue, alpha_out
    output logic                               m_tlast,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptr_pkg::PTR_ADDR_W-1:0]     paddr,
    input  logic [ptr_pkg::PTR_DATA_W-1:0]     pwdata,
    output logic [ptr_pkg::PTR_DATA_W-1:0]     prdata,
    output logic                               pready
);

    ptr_pkg::ptr_mode_t mode_reg;
    logic               adv;
    logic               full;
    ptr_pkg::ptr_pix_t  fin;
    ptr_pkg::ptr_pix_t  out_data;

    logic               valid_chain [ptr_pkg::PTR_CELLS+1];
    ptr_pkg::ptr_item_t item_chain  [ptr_pkg::PTR_CELLS+1];

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ptr_pkg::MODE_GRAY;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ptr_pkg::PTR_REG_MODE))
        begin
            mode_reg <= ptr_pkg::ptr_mode_t'(pwdata[1:0]);
        end
    end

    assign prdata = (paddr[2] == ptr_pkg::PTR_REG_MODE)
                    ? {{(ptr_pkg::PTR_DATA_W - 2){1'b0}}, mode_reg} : '0;

    assign adv      = !full;
    assign s_tready = adv;

    ptr_prep u_prep
    (
        .mode          (mode_reg),
        .sample_first  (s_tdata[7:0]),
        .sample_second (s_tdata[15:8]),
        .sample_third  (s_tdata[23:16]),
        .sample_fourth (s_tdata[31:24]),
        .last_in       (s_tlast),
        .item          (item_chain[0])
    );

    assign valid_chain[0] = s_tvalid;

    for (genvar k = 0; k < ptr_pkg::PTR_CELLS; k++)
    begin : g_cell
        ptr_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (valid_chain[k]),
            .in_item   (item_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_item  (item_chain[k+1])
        );
    end

    // clipped lanes read as full scale
    always_comb
    begin
        fin.red   = item_chain[ptr_pkg::PTR_CELLS].sat[0]
                    ? ptr_pkg::PTR_MAX_CHANNEL : item_chain[ptr_pkg::PTR_CELLS].lane[0].low;
        fin.green = item_chain[ptr_pkg::PTR_CELLS].sat[1]
                    ? ptr_pkg::PTR_MAX_CHANNEL : item_chain[ptr_pkg::PTR_CELLS].lane[1].low;
        fin.blue  = item_chain[ptr_pkg::PTR_CELLS].sat[2]
                    ? ptr_pkg::PTR_MAX_CHANNEL : item_chain[ptr_pkg::PTR_CELLS].lane[2].low;
        fin.alpha = item_chain[ptr_pkg::PTR_CELLS].alpha;
        fin.last  = item_chain[ptr_pkg::PTR_CELLS].last;
    end

    ptr_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv && valid_chain[ptr_pkg::PTR_CELLS]),
        .push_data (fin),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .full      (full)
    );

    assign m_tdata = {out_data.alpha, out_data.blue, out_data.green, out_data.red};
    assign m_tlast = out_data.last;

endmodule

[hdl/ptr_prep.sv]
module ptr_prep
(
    input  ptr_pkg::ptr_mode_t                  mode,
    input  logic [ptr_pkg::PTR_CH_W-1:0]        sample_first,
    input  logic [ptr_pkg::PTR_CH_W-1:0]        sample_second,
    input  logic [ptr_pkg::PTR_CH_W-1:0]        sample_third,
    input  logic [ptr_pkg::PTR_CH_W-1:0]        sample_fourth,
    input  logic                                last_in,
    output ptr_pkg::ptr_item_t                  item
);

    logic [ptr_pkg::PTR_LANES-1:0][ptr_pkg::PTR_CH_W-1:0]  value;
    logic [ptr_pkg::PTR_LANES-1:0][ptr_pkg::PTR_NUM_W-1:0] num;

    always_comb
    begin
        if (mode == ptr_pkg::MODE_GRAY)
        begin
            value[0] = sample_first;
            value[1] = sample_first;
            value[2] = sample_first;
        end
        else
        begin
            value[0] = sample_first;
            value[1] = sample_second;
            value[2] = sample_third;
        end
    end

    // v*255 + alpha/2, as (v << 8) - v + (alpha >> 1)
    always_comb
    begin
        for (int i = 0; i < ptr_pkg::PTR_LANES; i++)
        begin
            num[i] = {value[i], {ptr_pkg::PTR_CH_W{1'b0}}}
                     - {{ptr_pkg::PTR_CH_W{1'b0}}, value[i]}
                     + {{(ptr_pkg::PTR_CH_W + 1){1'b0}},
                        sample_fourth[ptr_pkg::PTR_CH_W-1:1]};
        end
    end

    always_comb
    begin
        item.last    = last_in;
        item.sat     = '0;
        item.divisor = ptr_pkg::PTR_UNIT_DIV;
        case (mode)
            ptr_pkg::MODE_GRAY,
            ptr_pkg::MODE_RGB:
            begin
                item.alpha = ptr_pkg::PTR_MAX_CHANNEL;
            end
            default:
            begin
                item.alpha = sample_fourth;
            end
        endcase
        // dividing by one with a zero remainder leaves low unchanged
        for (int i = 0; i < ptr_pkg::PTR_LANES; i++)
        begin
            item.lane[i].rem = '0;
            item.lane[i].low = value[i];
        end
        if (mode == ptr_pkg::MODE_PREMUL)
        begin
            if (sample_fourth == '0)
            begin
                for (int i = 0; i < ptr_pkg::PTR_LANES; i++)
                begin
                    item.lane[i].low = '0;
                end
            end
            else
            begin
                item.divisor = sample_fourth;
                for (int i = 0; i < ptr_pkg::PTR_LANES; i++)
                begin
                    // color at or above alpha always clips
                    item.sat[i] = (value[i] >= sample_fourth);
                    if (item.sat[i])
                    begin
                        item.lane[i].low = '0;
                    end
                    else
                    begin
                        item.lane[i].rem = num[i][ptr_pkg::PTR_NUM_W-1:ptr_pkg::PTR_CH_W];
                        item.lane[i].low = num[i][ptr_pkg::PTR_CH_W-1:0];
                    end
                end
            end
        end
    end

endmodule

[hdl/ptr_cell.sv]
module ptr_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ptr_pkg::ptr_item_t in_item,
    output logic               out_valid,
    output ptr_pkg::ptr_item_t out_item
);

    logic               valid_reg;
    ptr_pkg::ptr_item_t item_reg;
    ptr_pkg::ptr_item_t item_next;

    logic [ptr_pkg::PTR_LANES-1:0][ptr_pkg::PTR_CH_W:0] trial;
    logic [ptr_pkg::PTR_LANES-1:0][ptr_pkg::PTR_CH_W:0] diff;
    logic [ptr_pkg::PTR_LANES-1:0]                      ge;

    // one restoring step: bring in the next numerator bit, try to subtract
    always_comb
    begin
        item_next = in_item;
        for (int i = 0; i < ptr_pkg::PTR_LANES; i++)
        begin
            trial[i] = {in_item.lane[i].rem, in_item.lane[i].low[ptr_pkg::PTR_CH_W-1]};
            diff[i]  = trial[i] - {1'b0, in_item.divisor};
            ge[i]    = (trial[i] >= {1'b0, in_item.divisor});
            item_next.lane[i].rem = ge[i] ? diff[i][ptr_pkg::PTR_CH_W-1:0]
                                          : trial[i][ptr_pkg::PTR_CH_W-1:0];
            item_next.lane[i].low = {in_item.lane[i].low[ptr_pkg::PTR_CH_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hdl/ptr_skid.sv]
module ptr_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ptr_pkg::ptr_pix_t push_data,
    input  logic              pop_ready,
    output logic              out_valid,
    output ptr_pkg::ptr_pix_t out_data,
    output logic              full
);

    logic              out_valid_reg;
    ptr_pkg::ptr_pix_t out_data_reg;
    logic              skid_valid_reg;
    ptr_pkg::ptr_pix_t skid_data_reg;
    logic              load;

    assign load = !out_valid_reg || pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule
